@@ rtl/bgrl_pkg.sv @@
// ----------------------------------------------------------------------------
// bgrl_pkg
// Shared types and constants of the bus gain ramp and lowpass channel strip.
// ----------------------------------------------------------------------------
package bgrl_pkg;

    localparam int unsigned GAIN_W  = 19;
    localparam int unsigned STEP_W  = 20;
    localparam int unsigned ALPHA_W = 17;
    localparam int unsigned LEVEL_W = 17;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;

    localparam logic [GAIN_W-1:0]  GAIN_MAX  = 19'd262144;
    localparam logic [GAIN_W-1:0]  GAIN_INIT = 19'd65536;
    localparam logic [ALPHA_W-1:0] UNITY_Q16 = 17'd65536;

    typedef enum logic [1:0] {
        REG_TARGET_GAIN    = 2'd0,
        REG_LOWPASS_ALPHA  = 2'd1,
        REG_LOWPASS_ENABLE = 2'd2,
        REG_SEND_LEVEL     = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  target;
        logic [ALPHA_W-1:0] alpha;
        logic               enable;
        logic [LEVEL_W-1:0] level;
    } cfg_t;

    typedef struct packed {
        logic              start;
        logic [GAIN_W-1:0] num;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [GAIN_W-1:0] quot;
    } div_rsp_t;

endpackage

@@ rtl/bus_gain_ramp_lowpass_unit.sv @@
// ----------------------------------------------------------------------------
// bus_gain_ramp_lowpass_unit
// Mixer bus channel strip: gain ramp, optional one-pole lowpass and a mono
// reverb send, with an APB register port.
//
//   Channel  Handshake                 Payload
//   sample   sample_valid/ready        left_in, right_in, block_start
//   result   result_valid/ready        left_out, right_out, reverb_out
//   config   psel/penable/pwrite       paddr, pwdata, prdata
//
// A transaction passes through the shared multiplier sequence, S_GAIN to S_OUT.
// A block start first waits in S_DIV for the ramp step division.
// Reset clears the gain, ramp step and filter state; no clearing pass.
// A two-entry queue accepts up to two samples while the output register stalls.
// ----------------------------------------------------------------------------
module bus_gain_ramp_lowpass_unit #(
    parameter int SAMPLE_BITS = 24,
    parameter int RAMP_LENGTH = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  logic [SAMPLE_BITS-1:0]        left_in,
    input  logic [SAMPLE_BITS-1:0]        right_in,
    input  logic                          block_start,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [SAMPLE_BITS-1:0]        left_out,
    output logic [SAMPLE_BITS-1:0]        right_out,
    output logic [SAMPLE_BITS-1:0]        reverb_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bgrl_pkg::ADDR_W-1:0]   paddr,
    input  logic [bgrl_pkg::DATA_W-1:0]   pwdata,
    output logic [bgrl_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int QW = 2 * SAMPLE_BITS + 1;

    logic [bgrl_pkg::GAIN_W-1:0]  target_reg;
    logic [bgrl_pkg::ALPHA_W-1:0] alpha_reg;
    logic                         enable_reg;
    logic [bgrl_pkg::LEVEL_W-1:0] level_reg;
    bgrl_pkg::reg_idx_t           reg_idx;
    logic                         cfg_write;
    bgrl_pkg::cfg_t               cfg;
    bgrl_pkg::div_req_t           div_req;
    bgrl_pkg::div_rsp_t           div_rsp;
    logic [QW-1:0]                q_in;
    logic [QW-1:0]                q_out;
    logic                         q_valid;
    logic                         q_pop;

    assign pready    = 1'b1;
    assign reg_idx   = bgrl_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= bgrl_pkg::GAIN_INIT;
            alpha_reg  <= bgrl_pkg::UNITY_Q16;
            enable_reg <= 1'b0;
            level_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                bgrl_pkg::REG_TARGET_GAIN:    target_reg <= pwdata[bgrl_pkg::GAIN_W-1:0];
                bgrl_pkg::REG_LOWPASS_ALPHA:  alpha_reg  <= pwdata[bgrl_pkg::ALPHA_W-1:0];
                bgrl_pkg::REG_LOWPASS_ENABLE: enable_reg <= pwdata[0];
                bgrl_pkg::REG_SEND_LEVEL:     level_reg  <= pwdata[bgrl_pkg::LEVEL_W-1:0];
                default:                      enable_reg <= enable_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            bgrl_pkg::REG_TARGET_GAIN:    prdata = {13'd0, target_reg};
            bgrl_pkg::REG_LOWPASS_ALPHA:  prdata = {15'd0, alpha_reg};
            bgrl_pkg::REG_LOWPASS_ENABLE: prdata = {31'd0, enable_reg};
            bgrl_pkg::REG_SEND_LEVEL:     prdata = {15'd0, level_reg};
            default:                      prdata = '0;
        endcase
    end

    assign cfg.target = (target_reg > bgrl_pkg::GAIN_MAX) ? bgrl_pkg::GAIN_MAX : target_reg;
    assign cfg.alpha  = (alpha_reg > bgrl_pkg::UNITY_Q16) ? bgrl_pkg::UNITY_Q16 : alpha_reg;
    assign cfg.enable = enable_reg;
    assign cfg.level  = (level_reg > bgrl_pkg::UNITY_Q16) ? bgrl_pkg::UNITY_Q16 : level_reg;

    assign q_in = {block_start, right_in, left_in};

    bgrl_front #(
        .WIDTH (QW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_valid),
        .in_ready  (sample_ready),
        .in_data   (q_in),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_data  (q_out)
    );

    bgrl_div #(
        .RAMP_LENGTH (RAMP_LENGTH)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    bgrl_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .item_valid       (q_valid),
        .item_pop         (q_pop),
        .item_left        (q_out[SAMPLE_BITS-1:0]),
        .item_right       (q_out[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .item_block_start (q_out[QW-1]),
        .div_req          (div_req),
        .div_rsp          (div_rsp),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .left_out         (left_out),
        .right_out        (right_out),
        .reverb_out       (reverb_out)
    );

endmodule

@@ rtl/bgrl_front.sv @@
// ----------------------------------------------------------------------------
// bgrl_front
// Input side: accepts sample transactions into a two-entry queue.
// ----------------------------------------------------------------------------
module bgrl_front #(
    parameter int WIDTH = 49
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_pop,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

@@ rtl/bgrl_div.sv @@
// ----------------------------------------------------------------------------
// bgrl_div
// Divides the ramp distance by the ramp length. The distance is multiplied by
// the rounded-up reciprocal of the length, which gives the exact floor of the
// quotient over the whole distance range; the quotient is registered and ready
// in the cycle after the request.
// ----------------------------------------------------------------------------
module bgrl_div #(
    parameter int RAMP_LENGTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bgrl_pkg::div_req_t req,
    output bgrl_pkg::div_rsp_t rsp
);

    localparam int NUM_W = bgrl_pkg::GAIN_W;
    localparam int MW    = NUM_W + 1;
    localparam int SHIFT = NUM_W + $clog2(RAMP_LENGTH);
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(RAMP_LENGTH) - 64'd1) / 64'(RAMP_LENGTH);
    localparam logic [MW-1:0] RECIP = MW'(RECIP_FULL);

    logic                done_reg;
    logic [NUM_W-1:0]    quot_reg;
    logic [NUM_W+MW-1:0] prod;

    assign prod = req.num * RECIP;

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= req.start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quot_reg <= NUM_W'(prod >> SHIFT);
        end
    end

endmodule

@@ rtl/bgrl_back.sv @@
// ----------------------------------------------------------------------------
// bgrl_back
// Processing side: gain ramp, gain multiply, optional one-pole lowpass and reverb
// send, sequenced over one shared multiplier, with a registered result.
// ----------------------------------------------------------------------------
module bgrl_back #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  bgrl_pkg::cfg_t         cfg,
    input  logic                   item_valid,
    output logic                   item_pop,
    input  logic [SAMPLE_BITS-1:0] item_left,
    input  logic [SAMPLE_BITS-1:0] item_right,
    input  logic                   item_block_start,
    output bgrl_pkg::div_req_t     div_req,
    input  bgrl_pkg::div_rsp_t     div_rsp,
    output logic                   result_valid,
    input  logic                   result_ready,
    output logic [SAMPLE_BITS-1:0] left_out,
    output logic [SAMPLE_BITS-1:0] right_out,
    output logic [SAMPLE_BITS-1:0] reverb_out
);

    localparam int SB = SAMPLE_BITS;
    localparam int GW = SB + 8;
    localparam int AW = SB + 9;
    localparam int BW = bgrl_pkg::STEP_W;
    localparam int PW = AW + BW;
    localparam int NW = bgrl_pkg::GAIN_W;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DIV   = 10'b0000000010,
        S_GAIN  = 10'b0000000100,
        S_MUL_L = 10'b0000001000,
        S_MUL_R = 10'b0000010000,
        S_FLT_L = 10'b0000100000,
        S_FLT_R = 10'b0001000000,
        S_MONO  = 10'b0010000000,
        S_SEND  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    logic [NW-1:0]   gain_reg;
    logic [NW-1:0]   gain_next;
    logic [BW-1:0]   step_reg;
    logic            neg_reg;
    logic [SB-1:0]   xl_reg;
    logic [SB-1:0]   xr_reg;
    logic [GW-1:0]   gl_reg;
    logic [GW-1:0]   gr_reg;
    logic [GW-1:0]   fl_reg;
    logic [GW-1:0]   fr_reg;
    logic [PW-1:0]   prod_reg;
    logic            out_valid_reg;
    logic [SB-1:0]   left_out_reg;
    logic [SB-1:0]   right_out_reg;
    logic [SB-1:0]   reverb_out_reg;

    logic [BW-1:0]        diff;
    logic [BW-1:0]        quot_step;
    logic signed [BW:0]   gain_sum;
    logic signed [BW:0]   tgt_ext;
    logic                 step_pos;
    logic                 step_neg;
    logic signed [AW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] mul_p;
    logic [GW-1:0]        gained;
    logic [GW-1:0]        fl_new;
    logic [GW-1:0]        fr_new;
    logic [SB-1:0]        yl;
    logic [SB-1:0]        yr;
    logic [SB:0]          pair_sum;
    logic [SB-1:0]        mono;
    logic                 out_load;

    function automatic logic [GW-1:0] sat_gained(input logic [PW-1:0] p);
        logic [PW-GW-8:0] upper;
        logic [GW-1:0]    res;
        upper = p[PW-1:GW+7];
        if ((upper == '0) || (upper == '1))
        begin
            res = p[GW+7:8];
        end
        else if (p[PW-1])
        begin
            res = {1'b1, {(GW-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(GW-1){1'b1}}};
        end
        return res;
    endfunction

    assign diff = {1'b0, cfg.target} - {1'b0, gain_reg};
    assign div_req.start = (state_reg == S_IDLE) && item_valid && item_block_start;
    assign div_req.num   = diff[BW-1] ? ~diff[NW-1:0] : diff[NW-1:0];
    assign item_pop      = (state_reg == S_IDLE) && item_valid;
    assign quot_step     = neg_reg ? ~{1'b0, div_rsp.quot} : {1'b0, div_rsp.quot};

    assign gain_sum = $signed({2'b00, gain_reg}) + $signed({step_reg[BW-1], step_reg});
    assign tgt_ext  = $signed({2'b00, cfg.target});
    assign step_pos = !step_reg[BW-1] && (step_reg != '0);
    assign step_neg = step_reg[BW-1];

    always_comb
    begin
        gain_next = cfg.target;
        if (step_pos && (gain_reg < cfg.target))
        begin
            if (gain_sum <= tgt_ext)
            begin
                gain_next = gain_sum[NW-1:0];
            end
        end
        else if (step_neg && (gain_reg > cfg.target))
        begin
            if (gain_sum >= tgt_ext)
            begin
                gain_next = gain_sum[NW-1:0];
            end
        end
    end

    assign yl       = gl_reg[GW-1:8];
    assign yr       = gr_reg[GW-1:8];
    assign pair_sum = {yl[SB-1], yl} + {yr[SB-1], yr};
    assign mono     = pair_sum[SB:1];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MUL_L:
            begin
                mul_a = {{(AW-SB){xl_reg[SB-1]}}, xl_reg};
                mul_b = {1'b0, gain_reg};
            end
            S_MUL_R:
            begin
                mul_a = {{(AW-SB){xr_reg[SB-1]}}, xr_reg};
                mul_b = {1'b0, gain_reg};
            end
            S_FLT_L:
            begin
                mul_a = {gl_reg[GW-1], gl_reg} - {fl_reg[GW-1], fl_reg};
                mul_b = {{(BW-bgrl_pkg::ALPHA_W){1'b0}}, cfg.alpha};
            end
            S_FLT_R:
            begin
                mul_a = {gr_reg[GW-1], gr_reg} - {fr_reg[GW-1], fr_reg};
                mul_b = {{(BW-bgrl_pkg::ALPHA_W){1'b0}}, cfg.alpha};
            end
            S_SEND:
            begin
                mul_a = {{(AW-SB){mono[SB-1]}}, mono};
                mul_b = {{(BW-bgrl_pkg::LEVEL_W){1'b0}}, cfg.level};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign gained   = sat_gained(prod_reg);
    assign fl_new   = fl_reg + prod_reg[GW+15:16];
    assign fr_new   = fr_reg + prod_reg[GW+15:16];
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || result_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = item_block_start ? S_DIV : S_GAIN;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_GAIN;
                end
            end
            S_GAIN:  state_next = S_MUL_L;
            S_MUL_L: state_next = S_MUL_R;
            S_MUL_R: state_next = S_FLT_L;
            S_FLT_L: state_next = S_FLT_R;
            S_FLT_R: state_next = S_MONO;
            S_MONO:  state_next = S_SEND;
            S_SEND:  state_next = S_OUT;
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gain_reg      <= '0;
            step_reg      <= '0;
            fl_reg        <= '0;
            fr_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_DIV) && div_rsp.done)
            begin
                step_reg <= quot_step;
            end
            if (state_reg == S_GAIN)
            begin
                gain_reg <= gain_next;
            end
            if ((state_reg == S_FLT_R) && cfg.enable)
            begin
                fl_reg <= fl_new;
            end
            if ((state_reg == S_MONO) && cfg.enable)
            begin
                fr_reg <= fr_new;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg != S_OUT)
        begin
            prod_reg <= mul_p;
        end
        if (item_pop)
        begin
            xl_reg  <= item_left;
            xr_reg  <= item_right;
            neg_reg <= diff[BW-1];
        end
        if (state_reg == S_MUL_R)
        begin
            gl_reg <= gained;
        end
        if (state_reg == S_FLT_L)
        begin
            gr_reg <= gained;
        end
        if ((state_reg == S_FLT_R) && cfg.enable)
        begin
            gl_reg <= fl_new;
        end
        if ((state_reg == S_MONO) && cfg.enable)
        begin
            gr_reg <= fr_new;
        end
        if (out_load)
        begin
            left_out_reg   <= yl;
            right_out_reg  <= yr;
            reverb_out_reg <= prod_reg[SB+15:16];
        end
    end

    assign result_valid = out_valid_reg;
    assign left_out     = left_out_reg;
    assign right_out    = right_out_reg;
    assign reverb_out   = reverb_out_reg;

    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        gain_reg <= bgrl_pkg::GAIN_MAX)
        else $error("Current gain exceeds the maximum gain.");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == S_DIV)
        else $error("Divider finished outside the divide wait.");

    a_pop_leads_on: assert property (@(posedge clk) disable iff (!rst_n)
        item_pop |=> (state_reg == S_DIV) || (state_reg == S_GAIN))
        else $error("Popped transaction not taken into processing.");

    a_out_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) && out_valid_reg && !result_ready |=> state_reg == S_OUT)
        else $error("Result dropped while the output register was full.");

endmodule
